FILE: sv/assert_macros.svh
// Assertion macros shared by the RTL files.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: sv/gass_pkg.sv
`timescale 1ns / 1ps

package gass_pkg;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 25;

    typedef enum logic [CfgIdxW-1:0] {
        REG_HOLD_SECONDS     = 3'd0,
        REG_SETTLE_BAND      = 3'd1,
        REG_YAW_SWEEP_STEP   = 3'd2,
        REG_PITCH_SWEEP_STEP = 3'd3,
        REG_PITCH_TOP        = 3'd4,
        REG_PITCH_BOTTOM     = 3'd5
    } cfg_idx_t;

    // 180/pi in Q20.
    localparam logic signed [26:0] DegPerRadQ20 = 27'sd60078979;
    localparam logic signed [58:0] RoundHalf    = 59'sd524288;

    localparam logic [7:0]         HoldSecondsRst    = 8'd3;
    localparam logic [15:0]        SettleBandRst     = 16'd9830;
    localparam logic [15:0]        YawSweepStepRst   = 16'd6554;
    localparam logic [15:0]        PitchSweepStepRst = 16'd1966;
    localparam logic signed [24:0] PitchTopRst       = 25'sd983040;
    localparam logic signed [24:0] PitchBottomRst    = -25'sd1769472;
    localparam logic [31:0]        LastSightRst      = 32'd10;

    typedef struct packed {
        logic [31:0]        time_s;
        logic               aim_seen;
        logic signed [31:0] aim_yaw_rad;
        logic signed [31:0] aim_pitch_rad;
        logic               fire_request;
        logic signed [31:0] yaw_meas;
        logic signed [31:0] yaw_meas_prev;
        logic signed [31:0] pitch_meas;
        logic [12:0]        enc_count;
        logic [12:0]        enc_count_prev;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] yaw_target;
        logic signed [31:0] pitch_target;
        logic               fire_out;
        logic               tracking;
    } out_item_t;

    typedef struct packed {
        logic [7:0]         hold_seconds;
        logic [15:0]        settle_band;
        logic [15:0]        yaw_sweep_step;
        logic [15:0]        pitch_sweep_step;
        logic signed [24:0] pitch_top;
        logic signed [24:0] pitch_bottom;
    } cfg_t;

    // Q16 radians to Q16 degrees, rounded half up, wrapping to 32 bits.
    function automatic logic signed [31:0] rad_to_deg(input logic signed [31:0] rad);
        logic signed [58:0] prod;
        logic signed [58:0] q;
        prod = 59'(rad) * 59'(DegPerRadQ20);
        q    = prod + RoundHalf;
        return q[51:20];
    endfunction

endpackage

FILE: sv/gass_in_if.sv
`timescale 1ns / 1ps

interface gass_in_if
    import gass_pkg::*;
();
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: sv/gass_out_if.sv
`timescale 1ns / 1ps

interface gass_out_if
    import gass_pkg::*;
();
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: sv/gass_cfg_if.sv
`timescale 1ns / 1ps

interface gass_cfg_if
    import gass_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

FILE: sv/gass_cfg_regs.sv
`timescale 1ns / 1ps

module gass_cfg_regs
    import gass_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    gass_cfg_if.sink   cfg,
    output cfg_t       regs
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign regs      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg_idx_t'(cfg.index))
                REG_HOLD_SECONDS:     cfg_next.hold_seconds     = cfg.wdata[7:0];
                REG_SETTLE_BAND:      cfg_next.settle_band      = cfg.wdata[15:0];
                REG_YAW_SWEEP_STEP:   cfg_next.yaw_sweep_step   = cfg.wdata[15:0];
                REG_PITCH_SWEEP_STEP: cfg_next.pitch_sweep_step = cfg.wdata[15:0];
                REG_PITCH_TOP:        cfg_next.pitch_top        = cfg.wdata;
                REG_PITCH_BOTTOM:     cfg_next.pitch_bottom     = cfg.wdata;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_seconds     <= HoldSecondsRst;
            cfg_reg.settle_band      <= SettleBandRst;
            cfg_reg.yaw_sweep_step   <= YawSweepStepRst;
            cfg_reg.pitch_sweep_step <= PitchSweepStepRst;
            cfg_reg.pitch_top        <= PitchTopRst;
            cfg_reg.pitch_bottom     <= PitchBottomRst;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: sv/gass_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gass_core
    import gass_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      adv,
    input  in_item_t  item,
    output out_item_t result
);

    logic        aim_active_reg, aim_active_next;
    logic [31:0] last_sight_reg, last_sight_next;
    logic [31:0] yaw_sp_reg, yaw_sp_next;
    logic [31:0] pitch_sp_reg, pitch_sp_next;
    logic        yaw_up_reg, yaw_up_next;
    logic        pitch_up_reg, pitch_up_next;

    logic               active_or;
    logic signed [32:0] elapsed;
    logic signed [32:0] hold_ext;
    logic signed [32:0] dyaw;
    logic signed [32:0] band_ext;
    logic               in_hold;
    logic               settled;
    logic               track;
    logic signed [31:0] yaw_deg;
    logic signed [31:0] pitch_deg;

    assign yaw_deg   = rad_to_deg(item.aim_yaw_rad);
    assign pitch_deg = rad_to_deg(item.aim_pitch_rad);

    always_comb
    begin
        active_or = aim_active_reg | item.aim_seen;
        elapsed   = $signed({1'b0, item.time_s}) - $signed({1'b0, last_sight_reg});
        hold_ext  = $signed({25'd0, cfg.hold_seconds});
        in_hold   = elapsed < hold_ext;
        track     = active_or | in_hold;
        dyaw      = 33'(item.yaw_meas) - 33'(item.yaw_meas_prev);
        band_ext  = $signed({17'd0, cfg.settle_band});
        settled   = (dyaw <= band_ext) && (dyaw >= -band_ext);

        aim_active_next = active_or;
        last_sight_next = last_sight_reg;
        yaw_sp_next     = yaw_sp_reg;
        pitch_sp_next   = pitch_sp_reg;
        yaw_up_next     = yaw_up_reg;
        pitch_up_next   = pitch_up_reg;

        if (track)
        begin
            if (active_or)
            begin
                last_sight_next = item.time_s;
            end
            yaw_sp_next   = yaw_deg;
            pitch_sp_next = pitch_deg;
            if (settled)
            begin
                aim_active_next = 1'b0;
            end
        end
        else
        begin
            if (yaw_up_reg)
            begin
                yaw_sp_next = yaw_sp_reg + {16'd0, cfg.yaw_sweep_step};
            end
            else
            begin
                yaw_sp_next = yaw_sp_reg - {16'd0, cfg.yaw_sweep_step};
            end
            if (item.enc_count == item.enc_count_prev)
            begin
                yaw_up_next = !yaw_up_reg;
            end

            if (pitch_up_reg)
            begin
                pitch_sp_next = pitch_sp_reg + {16'd0, cfg.pitch_sweep_step};
                if (item.pitch_meas >= 32'(cfg.pitch_top))
                begin
                    pitch_up_next = 1'b0;
                end
            end
            else
            begin
                pitch_sp_next = pitch_sp_reg - {16'd0, cfg.pitch_sweep_step};
                if (item.pitch_meas <= 32'(cfg.pitch_bottom))
                begin
                    pitch_up_next = 1'b1;
                end
            end
        end

        result.yaw_target   = yaw_sp_next;
        result.pitch_target = pitch_sp_next;
        result.fire_out     = track & item.fire_request;
        result.tracking     = track;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aim_active_reg <= 1'b0;
            last_sight_reg <= LastSightRst;
            yaw_sp_reg     <= 32'd0;
            pitch_sp_reg   <= 32'd0;
            yaw_up_reg     <= 1'b0;
            pitch_up_reg   <= 1'b0;
        end
        else if (adv)
        begin
            aim_active_reg <= aim_active_next;
            last_sight_reg <= last_sight_next;
            yaw_sp_reg     <= yaw_sp_next;
            pitch_sp_reg   <= pitch_sp_next;
            yaw_up_reg     <= yaw_up_next;
            pitch_up_reg   <= pitch_up_next;
        end
    end

    // A scanning item can only follow a cleared aim flag, and it leaves it clear.
    `ASSERT_NEXT(a_scan_keeps_flag_clear, adv && !result.tracking, !aim_active_reg)
    // A sighting always restarts the hold time from the item's own time.
    `ASSERT_NEXT(a_sight_sets_time, adv && item.aim_seen, last_sight_reg == $past(item.time_s))

endmodule

FILE: sv/gimbal_aim_scan_sequencer.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Gimbal aim and scan sequencer. The block accepts one item per clock while
// the result side is not stalled and returns one result per item. An
// accepted item is held in an input register; one compute stage, with one
// constant multiplier per angle for the radian to degree conversion, updates
// the aim and scan state and writes the result register. The state update
// closes within that single stage, so a new item can follow in every cycle
// unless the result side stalls. Configuration registers are written through
// the cfg channel, which is always ready, and take effect for the next item.

module gimbal_aim_scan_sequencer
    import gass_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    gass_in_if.sink     tick,
    gass_out_if.source  result,
    gass_cfg_if.sink    cfg
);

    cfg_t      regs;
    out_item_t core_result;

    logic      s1_vld_reg, s1_vld_next;
    in_item_t  s1_item_reg;
    logic      out_vld_reg, out_vld_next;
    out_item_t out_item_reg;

    logic      out_free;
    logic      s1_adv;
    logic      accept;

    gass_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    gass_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (regs),
        .adv    (s1_adv),
        .item   (s1_item_reg),
        .result (core_result)
    );

    always_comb
    begin
        out_free     = !out_vld_reg || result.ready;
        s1_adv       = s1_vld_reg && out_free;
        tick.ready   = !s1_vld_reg || out_free;
        accept       = tick.valid && tick.ready;
        s1_vld_next  = accept || (s1_vld_reg && !s1_adv);
        out_vld_next = s1_adv || (out_vld_reg && !result.ready);
    end

    assign result.valid = out_vld_reg;
    assign result.data  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg  <= s1_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= tick.data;
        end
        if (s1_adv)
        begin
            out_item_reg <= core_result;
        end
    end

    `ASSERT_SAME(a_ready_when_empty, !s1_vld_reg, tick.ready)
    `ASSERT_NEXT(a_adv_fills_result, s1_adv, out_vld_reg)
    `ASSERT_SAME(a_fire_gated, out_vld_reg && !out_item_reg.tracking, !out_item_reg.fire_out)

endmodule

FILE: bench/gimbal_aim_scan_sequencer_test.sv
`timescale 1ns / 1ps

module gimbal_aim_scan_sequencer_test;
    import gass_pkg::*;

    localparam int CycleLimit = 200000;
    localparam int ItemsPerPhase = 75;
    localparam int PhaseCount = 6;
    localparam int HoldOffCycles = 300;
    localparam logic [CfgIdxW-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CfgIdxW-1:0] REG_SPARE_B = 3'd7;
    localparam logic signed [24:0] PitchLimit = 25'sd11796480;

    // Tracks the aim and scan state of the block and holds the set-points it should emit.
    class aim_scan_scoreboard;
        localparam longint RadToDegQ20 = 60078979;

        cfg_t        regs;
        logic        aim_active;
        logic [31:0] last_sight_s;
        logic [31:0] yaw_sp;
        logic [31:0] pitch_sp;
        logic        yaw_up;
        logic        pitch_up;
        out_item_t   expected_q[$];
        int          errors;

        function new();
            regs.hold_seconds     = HoldSecondsRst;
            regs.settle_band      = SettleBandRst;
            regs.yaw_sweep_step   = YawSweepStepRst;
            regs.pitch_sweep_step = PitchSweepStepRst;
            regs.pitch_top        = PitchTopRst;
            regs.pitch_bottom     = PitchBottomRst;
            aim_active   = 1'b0;
            last_sight_s = LastSightRst;
            yaw_sp       = '0;
            pitch_sp     = '0;
            yaw_up       = 1'b0;
            pitch_up     = 1'b0;
            errors       = 0;
        endfunction

        function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
            case (idx)
                REG_HOLD_SECONDS:     regs.hold_seconds = val[7:0];
                REG_SETTLE_BAND:      regs.settle_band = val[15:0];
                REG_YAW_SWEEP_STEP:   regs.yaw_sweep_step = val[15:0];
                REG_PITCH_SWEEP_STEP: regs.pitch_sweep_step = val[15:0];
                REG_PITCH_TOP:        regs.pitch_top = val[24:0];
                REG_PITCH_BOTTOM:     regs.pitch_bottom = val[24:0];
                default:              ;
            endcase
        endfunction

        // The product is rounded half up, so an arithmetic shift after adding half is exact.
        function logic [31:0] to_degrees(logic signed [31:0] rad);
            longint prod;
            prod = longint'(rad) * RadToDegQ20 + 64'sd524288;
            prod = prod >>> 20;
            return prod[31:0];
        endfunction

        function void note_tick(in_item_t it);
            longint    elapsed;
            longint    dyaw;
            longint    band;
            out_item_t r;
            elapsed = $signed({32'd0, it.time_s}) - $signed({32'd0, last_sight_s});
            dyaw = longint'($signed(it.yaw_meas)) - longint'($signed(it.yaw_meas_prev));
            band = longint'({48'd0, regs.settle_band});
            aim_active = aim_active | it.aim_seen;
            r = '0;
            if (aim_active || elapsed < longint'({56'd0, regs.hold_seconds}))
            begin
                if (aim_active)
                begin
                    last_sight_s = it.time_s;
                end
                yaw_sp = to_degrees(it.aim_yaw_rad);
                pitch_sp = to_degrees(it.aim_pitch_rad);
                if (dyaw <= band && dyaw >= -band)
                begin
                    aim_active = 1'b0;
                end
                r.fire_out = it.fire_request;
                r.tracking = 1'b1;
            end
            else
            begin
                yaw_sp = yaw_up ? yaw_sp + regs.yaw_sweep_step : yaw_sp - regs.yaw_sweep_step;
                if (it.enc_count == it.enc_count_prev)
                begin
                    yaw_up = !yaw_up;
                end
                if (pitch_up)
                begin
                    pitch_sp = pitch_sp + regs.pitch_sweep_step;
                    if (longint'($signed(it.pitch_meas)) >= longint'($signed(regs.pitch_top)))
                    begin
                        pitch_up = 1'b0;
                    end
                end
                else
                begin
                    pitch_sp = pitch_sp - regs.pitch_sweep_step;
                    if (longint'($signed(it.pitch_meas)) <= longint'($signed(regs.pitch_bottom)))
                    begin
                        pitch_up = 1'b1;
                    end
                end
            end
            r.yaw_target = yaw_sp;
            r.pitch_target = pitch_sp;
            expected_q.push_back(r);
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("mismatch at %0t: %s", $realtime, what);
        endtask

        task check_result(out_item_t got);
            out_item_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("result %h arrived with no item pending", got));
            end
            else
            begin
                want = expected_q.pop_front();
                if (got.yaw_target !== want.yaw_target)
                begin
                    report_mismatch($sformatf("yaw_target %h, expected %h",
                                              got.yaw_target, want.yaw_target));
                end
                if (got.pitch_target !== want.pitch_target)
                begin
                    report_mismatch($sformatf("pitch_target %h, expected %h",
                                              got.pitch_target, want.pitch_target));
                end
                if (got.fire_out !== want.fire_out)
                begin
                    report_mismatch($sformatf("fire_out %b, expected %b",
                                              got.fire_out, want.fire_out));
                end
                if (got.tracking !== want.tracking)
                begin
                    report_mismatch($sformatf("tracking %b, expected %b",
                                              got.tracking, want.tracking));
                end
            end
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   recv_hold;
    int   cycle_count;
    logic [31:0] sim_now;
    aim_scan_scoreboard sb;

    gass_in_if  tick_if();
    gass_out_if result_if();
    gass_cfg_if cfg_if();

    gimbal_aim_scan_sequencer u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        if (recv_hold > 0)
        begin
            result_if.ready <= 1'b0;
            recv_hold = recv_hold - 1;
        end
        else
        begin
            result_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_if.valid && result_if.ready)
        begin
            sb.check_result(result_if.data);
        end
    end

    initial
    begin
        for (cycle_count = 0; cycle_count < CycleLimit; cycle_count++)
        begin
            @(posedge clk);
        end
        $display("TEST FAILED");
        $finish;
    end

    task send_tick(input in_item_t it);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            tick_if.valid <= 1'b0;
            @(negedge clk);
        end
        tick_if.valid <= 1'b1;
        tick_if.data <= it;
        @(posedge clk);
        while (!tick_if.ready)
        begin
            @(posedge clk);
        end
        sb.note_tick(it);
    endtask

    task stop_ticks();
        @(negedge clk);
        tick_if.valid <= 1'b0;
    endtask

    task wait_results();
        while (sb.pending() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.wdata <= val;
        @(posedge clk);
        while (!cfg_if.ready)
        begin
            @(posedge clk);
        end
        sb.write_reg(idx, val);
    endtask

    function automatic logic [24:0] rand_limit();
        int v;
        v = $urandom_range(0, 23592960);
        v = v - 11796480;
        return v[24:0];
    endfunction

    task apply_settings(input int phase);
        case (phase)
            1:
            begin
                write_reg(REG_HOLD_SECONDS, 25'd0);
                write_reg(REG_SETTLE_BAND, 25'd0);
                write_reg(REG_YAW_SWEEP_STEP, 25'd65535);
                write_reg(REG_PITCH_SWEEP_STEP, 25'd65535);
                write_reg(REG_PITCH_TOP, PitchLimit);
                write_reg(REG_PITCH_BOTTOM, -PitchLimit);
                write_reg(REG_SPARE_A, 25'($urandom));
                write_reg(REG_SPARE_B, 25'($urandom));
            end
            2:
            begin
                write_reg(REG_HOLD_SECONDS, 25'd255);
                write_reg(REG_SETTLE_BAND, 25'd65535);
                write_reg(REG_YAW_SWEEP_STEP, 25'd0);
                write_reg(REG_PITCH_SWEEP_STEP, 25'd0);
                write_reg(REG_PITCH_TOP, -PitchLimit);
                write_reg(REG_PITCH_BOTTOM, PitchLimit);
            end
            3, 4:
            begin
                write_reg(REG_HOLD_SECONDS, 25'($urandom_range(0, 15)) | (25'($urandom) & ~25'hFF));
                write_reg(REG_SETTLE_BAND, 25'($urandom));
                write_reg(REG_YAW_SWEEP_STEP, 25'($urandom));
                write_reg(REG_PITCH_SWEEP_STEP, 25'($urandom));
                write_reg(REG_PITCH_TOP, rand_limit());
                write_reg(REG_PITCH_BOTTOM, rand_limit());
                write_reg(REG_SPARE_B, 25'($urandom));
            end
            5:
            begin
                write_reg(REG_HOLD_SECONDS, 25'(HoldSecondsRst));
                write_reg(REG_SETTLE_BAND, 25'(SettleBandRst));
                write_reg(REG_YAW_SWEEP_STEP, 25'(YawSweepStepRst));
                write_reg(REG_PITCH_SWEEP_STEP, 25'(PitchSweepStepRst));
                write_reg(REG_PITCH_TOP, PitchTopRst);
                write_reg(REG_PITCH_BOTTOM, PitchBottomRst);
            end
            default: ;
        endcase
        if (phase != 0)
        begin
            @(negedge clk);
            cfg_if.valid <= 1'b0;
        end
    endtask

    function automatic in_item_t quiet_tick(input logic [31:0] t_s);
        in_item_t t;
        t = '0;
        t.time_s = t_s;
        t.enc_count = 13'd5;
        t.enc_count_prev = 13'd6;
        return t;
    endfunction

    // Walks the hold window edges, the settle band edges, both pitch reversals
    // and the encoder stall, starting from the reset state.
    task run_directed();
        in_item_t it;
        it = quiet_tick(32'd13);
        it.fire_request = 1'b1;
        send_tick(it);
        it = quiet_tick(32'd12);
        it.aim_yaw_rad = 32'sh7FFFFFFF;
        it.aim_pitch_rad = 32'sh80000000;
        it.fire_request = 1'b1;
        send_tick(it);
        it = quiet_tick(32'd0);
        it.aim_yaw_rad = -32'sd1;
        it.aim_pitch_rad = 32'sd1;
        send_tick(it);
        it = quiet_tick(32'd100);
        it.enc_count = 13'h1FFF;
        it.enc_count_prev = 13'h1FFF;
        it.pitch_meas = 32'(PitchBottomRst);
        send_tick(it);
        it = quiet_tick(32'd100);
        it.enc_count = 13'd0;
        it.enc_count_prev = 13'd0;
        it.pitch_meas = 32'(PitchTopRst);
        send_tick(it);
        it = quiet_tick(32'd101);
        it.enc_count = 13'h1FFF;
        it.enc_count_prev = 13'd0;
        it.pitch_meas = 32'sh7FFFFFFF;
        send_tick(it);
        it = quiet_tick(32'd101);
        it.pitch_meas = 32'sh80000000;
        it.fire_request = 1'b1;
        send_tick(it);
        it = quiet_tick(32'hFFFFFFFF);
        it.aim_seen = 1'b1;
        it.yaw_meas = 32'sh7FFFFFFF;
        it.yaw_meas_prev = 32'sh80000000;
        it.aim_yaw_rad = 32'sh80000000;
        it.aim_pitch_rad = 32'sh7FFFFFFF;
        it.fire_request = 1'b1;
        send_tick(it);
        it = quiet_tick(32'd0);
        it.yaw_meas = 32'(SettleBandRst);
        it.aim_yaw_rad = 32'sd205887;
        send_tick(it);
        it = quiet_tick(32'd3);
        send_tick(it);
        it = quiet_tick(32'd50);
        it.aim_seen = 1'b1;
        it.yaw_meas = 32'sh80000000;
        it.yaw_meas_prev = 32'sh7FFFFFFF;
        send_tick(it);
        it = quiet_tick(32'd60);
        it.yaw_meas_prev = 32'sd9831;
        send_tick(it);
        it = quiet_tick(32'd61);
        it.yaw_meas = -32'sd100;
        it.yaw_meas_prev = 32'sd9730;
        send_tick(it);
        it = quiet_tick(32'd63);
        send_tick(it);
        it = quiet_tick(32'd64);
        it.fire_request = 1'b1;
        send_tick(it);
        it = quiet_tick(32'd64);
        it.enc_count = 13'h1FFF;
        it.enc_count_prev = 13'h1FFF;
        it.pitch_meas = 32'sh7FFFFFFF;
        send_tick(it);
    endtask

    // Mostly a plausible tick stream: time creeps forward, sightings are sparse,
    // yaw changes sit near the settle band and pitch sits near the limits.
    function automatic in_item_t gen_tick();
        in_item_t t;
        int band_i;
        int dl;
        int pv;
        int off;
        int span;
        int sel;
        t = '0;
        if ($urandom_range(0, 99) < 15)
        begin
            t.time_s = $urandom;
            t.aim_seen = 1'($urandom);
            t.aim_yaw_rad = $urandom;
            t.aim_pitch_rad = $urandom;
            t.fire_request = 1'($urandom);
            t.yaw_meas = $urandom;
            t.yaw_meas_prev = $urandom;
            t.pitch_meas = $urandom;
            t.enc_count = 13'($urandom);
            t.enc_count_prev = 13'($urandom);
        end
        else
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                sim_now = sim_now + $urandom_range(1, 3);
            end
            if ($urandom_range(0, 49) == 0)
            begin
                span = $urandom_range(0, 600);
                sim_now = sim_now + span - 300;
            end
            t.time_s = sim_now;
            t.aim_seen = ($urandom_range(0, 99) < 12);
            t.fire_request = 1'($urandom);
            if ($urandom_range(0, 3) == 0)
            begin
                t.aim_yaw_rad = $urandom;
                t.aim_pitch_rad = $urandom;
            end
            else
            begin
                pv = $urandom_range(0, 411774);
                t.aim_yaw_rad = pv - 205887;
                pv = $urandom_range(0, 411774);
                t.aim_pitch_rad = pv - 205887;
            end
            if ($urandom_range(0, 3) == 0)
            begin
                t.yaw_meas_prev = $urandom;
            end
            else
            begin
                pv = $urandom_range(0, 2097152);
                t.yaw_meas_prev = pv - 1048576;
            end
            band_i = int'(sb.regs.settle_band);
            sel = $urandom_range(0, 9);
            case (sel)
                0: dl = band_i;
                1: dl = -band_i;
                2: dl = band_i + 1;
                3: dl = -band_i - 1;
                default:
                begin
                    dl = $urandom_range(0, 4 * band_i);
                    dl = dl - 2 * band_i;
                end
            endcase
            t.yaw_meas = t.yaw_meas_prev + dl;
            off = $urandom_range(0, 6);
            off = off - 3;
            case ($urandom_range(0, 3))
                0: t.pitch_meas = $signed(sb.regs.pitch_top) + off;
                1: t.pitch_meas = $signed(sb.regs.pitch_bottom) + off;
                2: t.pitch_meas = $urandom;
                default:
                begin
                    pv = $urandom_range(0, 23592960);
                    t.pitch_meas = pv - 11796480;
                end
            endcase
            t.enc_count_prev = 13'($urandom);
            t.enc_count = ($urandom_range(0, 99) < 35) ? t.enc_count_prev : 13'($urandom);
        end
        return t;
    endfunction

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        send_idle_pct = 29;
        recv_idle_pct = 57;
        recv_hold = 0;
        sim_now = '0;
        tick_if.valid = 1'b0;
        tick_if.data = '0;
        result_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.wdata = '0;
        repeat (5)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        rst_n = 1'b1;

        for (int phase = 0; phase < PhaseCount; phase++)
        begin
            @(posedge clk);
            if (phase < 2)
            begin
                send_idle_pct = 29;
                recv_idle_pct = 57;
            end
            else if (phase < 4)
            begin
                send_idle_pct = 57;
                recv_idle_pct = 29;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            apply_settings(phase);
            if (phase == 0)
            begin
                run_directed();
            end
            sim_now = $urandom;
            for (int n = 0; n < ItemsPerPhase; n++)
            begin
                send_tick(gen_tick());
                if (phase == 1 && n == 20)
                begin
                    recv_hold = HoldOffCycles;
                end
                if (phase == 3 && n == 40)
                begin
                    stop_ticks();
                    wait_results();
                end
            end
            stop_ticks();
            wait_results();
        end

        repeat (8)
        begin
            @(posedge clk);
        end
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+sv
sv/gass_pkg.sv
sv/gass_in_if.sv
sv/gass_out_if.sv
sv/gass_cfg_if.sv
sv/gass_cfg_regs.sv
sv/gass_core.sv
sv/gimbal_aim_scan_sequencer.sv
bench/gimbal_aim_scan_sequencer_test.sv
